>>> rtl/rvx_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rvx_pkg
// Shared codes and controller/datapath handshake types of the RV32 executor.
// -----------------------------------------------------------------------------
package rvx_pkg;

  localparam int unsigned XLEN = 32;

  localparam logic [5:0] F_ADDI  = 6'd0;
  localparam logic [5:0] F_ADD   = 6'd1;
  localparam logic [5:0] F_SUB   = 6'd2;
  localparam logic [5:0] F_MUL   = 6'd3;
  localparam logic [5:0] F_DIV   = 6'd4;
  localparam logic [5:0] F_REM   = 6'd5;
  localparam logic [5:0] F_SLT   = 6'd6;
  localparam logic [5:0] F_SLTU  = 6'd7;
  localparam logic [5:0] F_SLTIU = 6'd8;
  localparam logic [5:0] F_SLTI  = 6'd9;
  localparam logic [5:0] F_SLLI  = 6'd10;
  localparam logic [5:0] F_XORI  = 6'd11;
  localparam logic [5:0] F_SEQZ  = 6'd12;
  localparam logic [5:0] F_SNEZ  = 6'd13;
  localparam logic [5:0] F_LI    = 6'd14;
  localparam logic [5:0] F_MV    = 6'd15;
  localparam logic [5:0] F_NEG   = 6'd16;
  localparam logic [5:0] F_LW    = 6'd17;
  localparam logic [5:0] F_SW    = 6'd18;
  localparam logic [5:0] F_LA    = 6'd19;
  localparam logic [5:0] F_BEQZ  = 6'd20;
  localparam logic [5:0] F_BEQ   = 6'd21;
  localparam logic [5:0] F_BNEZ  = 6'd22;
  localparam logic [5:0] F_BNE   = 6'd23;
  localparam logic [5:0] F_BLT   = 6'd24;
  localparam logic [5:0] F_BGE   = 6'd25;
  localparam logic [5:0] F_J     = 6'd26;
  localparam logic [5:0] F_JAL   = 6'd27;
  localparam logic [5:0] F_CALL  = 6'd28;
  localparam logic [5:0] F_RET   = 6'd29;
  localparam logic [5:0] F_JALR  = 6'd30;
  localparam logic [5:0] F_DINIT = 6'd31;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_RET   = 3'd1;
  localparam logic [2:0] ST_PCOOR = 3'd2;
  localparam logic [2:0] ST_UNK   = 3'd3;
  localparam logic [2:0] ST_LIMIT = 3'd4;

  localparam logic [1:0] CFG_CODE_SIZE  = 2'd0;
  localparam logic [1:0] CFG_ENTRY_PC   = 2'd1;
  localparam logic [1:0] CFG_STEP_LIMIT = 2'd2;

  localparam logic [1:0] WB_ALU = 2'd0;
  localparam logic [1:0] WB_MEM = 2'd1;
  localparam logic [1:0] WB_DIV = 2'd2;

  localparam logic [4:0] REG_RA = 5'd1;
  localparam logic [4:0] REG_SP = 5'd2;
  localparam logic [4:0] REG_A0 = 5'd10;

  localparam logic [31:0] STEP_LIMIT_RST = 32'd200000000;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic commit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/rv32_subset_instruction_executor.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rv32_subset_instruction_executor
// Executes pre-decoded RV32IM-subset instructions, one result word per input.
// -----------------------------------------------------------------------------
// Channel   Dir  Handshake                  Content
// s_axis    in   s_axis_tvalid/tready       one instruction word
// m_axis    out  m_axis_tvalid/tready       next pc, status, exit code
// cfg       in   cfg_valid_i/cfg_ready_o    register index and write data
//
// An instruction passes through accept, register read, execute and commit;
// div and rem with a regular divisor add a pass through the iterative divider.
// After reset the data memory is cleared one word per cycle, every word in turn,
// while no instruction is accepted; configuration writes are taken throughout.
// A stalled result waits in the output register; the next word is accepted
// meanwhile and holds in commit until the result is taken.
// -----------------------------------------------------------------------------
module rv32_subset_instruction_executor #(
  parameter int unsigned MEM_WORDS  = 65536,
  parameter int unsigned CODE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // func[5:0], rd[10:6], rs1[15:11], rs2[20:16], imm[52:21],
  // target[64:53], data_address[82:65], zero fill[87:83]
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // next_pc[31:0], status[34:32], exit_code[42:35], zero fill[47:43]
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import rvx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rvx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rvx_dp #(
    .MEM_WORDS  (MEM_WORDS),
    .CODE_DEPTH (CODE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );
endmodule

`default_nettype wire

>>> rtl/rvx_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rvx_div
// Iterative signed divider, one quotient bit per cycle, RISC-V sign rules.
// -----------------------------------------------------------------------------
module rvx_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        rem_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [31:0]      res_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, rem_q, mb_q;
  logic        na_q, nb_q, want_rem_q;
  logic [32:0] trial;
  logic [31:0] shifted;

  assign shifted = {rem_q[30:0], quo_q[31]};
  assign trial   = {1'b0, shifted} - {1'b0, mb_q};

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      na_q       <= a_i[31];
      nb_q       <= b_i[31];
      want_rem_q <= rem_i;
      quo_q      <= a_i[31] ? (32'd0 - a_i) : a_i;
      mb_q       <= b_i[31] ? (32'd0 - b_i) : b_i;
      rem_q      <= 32'd0;
    end else if (cnt_q != 6'd0) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = (cnt_q == 6'd0);

  always_comb begin
    if (want_rem_q) begin
      res_o = na_q ? (32'd0 - rem_q) : rem_q;
    end else begin
      res_o = (na_q ^ nb_q) ? (32'd0 - quo_q) : quo_q;
    end
  end
endmodule

`default_nettype wire

>>> rtl/rvx_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rvx_ctrl
// Sequencer: memory clear, accept, register read, execute, divide, commit.
// -----------------------------------------------------------------------------
module rvx_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rvx_pkg::sts_t sts_i,
  output rvx_pkg::cmd_t      cmd_o
);
  import rvx_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("input accepted during memory clear");
  a_commit_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == S_IDLE))
    else $error("commit did not return to idle");
  a_exec_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> ($past(state_q) == S_READ))
    else $error("execute without register read");
`endif
endmodule

`default_nettype wire

>>> rtl/rvx_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// rvx_dp
// Datapath: configuration, register file, data memory, ALU and result register.
// -----------------------------------------------------------------------------
module rvx_dp #(
  parameter int unsigned MEM_WORDS  = 65536,
  parameter int unsigned CODE_DEPTH = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [87:0]   in_data_i,
  input  wire rvx_pkg::cmd_t cmd_i,
  output rvx_pkg::sts_t      sts_o,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [47:0]        out_data_o
);
  import rvx_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [31:0] SP_RST = 32'(4 * MEM_WORDS - 16);
  localparam logic [31:0] CODE_LIM = 32'(CODE_DEPTH);

  logic [12:0] size_q;
  logic [31:0] limit_q;
  logic [31:0] pc_q, step_q;
  logic [2:0]  status_q;
  logic [7:0]  a0_lo_q;

  logic [5:0]  func_q;
  logic [4:0]  rd_q, rs1_q, rs2_q;
  logic [31:0] imm_q;
  logic [11:0] tgt_q;
  logic [17:0] daddr_q;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] a_q, b_q;
  logic [4:0]  b_idx;

  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] mem_rdata_q;
  logic [AW-1:0] clr_cnt_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, ea, daddr_ext;

  logic [31:0] npc_q, alu_q;
  logic [2:0]  stn_q;
  logic        step_inc_q, wb_en_q;
  logic [4:0]  wb_rd_q;
  logic [1:0]  wb_sel_q;

  logic [31:0] eff, npc_d, alu_d, pc1, wb_data, div_res;
  logic [2:0]  stn_d;
  logic        step_inc_d, wb_en_d, exe, taken;
  logic [4:0]  wb_rd_d;
  logic [1:0]  wb_sel_d;
  logic        is_div, div_special, div_done;
  logic [31:0] div_special_val;

  function automatic logic [31:0] rf_rst(input logic [4:0] idx, input logic [31:0] sp);
    logic [31:0] v;
    v = 32'd0;
    if (idx == REG_RA) begin
      v = 32'hFFFF_FFFF;
    end else if (idx == REG_SP) begin
      v = sp;
    end
    return v;
  endfunction

  // Configuration registers and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= 13'd0;
      limit_q  <= STEP_LIMIT_RST;
      pc_q     <= 32'd0;
      step_q   <= 32'd0;
      status_q <= ST_RUN;
      a0_lo_q  <= 8'd0;
      rf_vld_q <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CODE_SIZE:  size_q  <= cfg_data_i[12:0];
          CFG_ENTRY_PC: begin
            if (step_q == 32'd0 && status_q == ST_RUN) begin
              pc_q <= {20'd0, cfg_data_i[11:0]};
            end
          end
          CFG_STEP_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        pc_q     <= npc_q;
        status_q <= stn_q;
        if (step_inc_q) begin
          step_q <= step_q + 32'd1;
        end
        if (wb_en_q && wb_rd_q != 5'd0) begin
          rf_vld_q[wb_rd_q] <= 1'b1;
          if (wb_rd_q == REG_A0) begin
            a0_lo_q <= wb_data[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= in_data_i[5:0];
      rd_q    <= in_data_i[10:6];
      rs1_q   <= in_data_i[15:11];
      rs2_q   <= in_data_i[20:16];
      imm_q   <= in_data_i[52:21];
      tgt_q   <= in_data_i[64:53];
      daddr_q <= in_data_i[82:65];
    end
  end

  // Register file: two registered read ports, one write port.
  always_comb begin
    if (func_q == F_SW) begin
      b_idx = rd_q;
    end else if (func_q == F_RET) begin
      b_idx = REG_RA;
    end else begin
      b_idx = rs2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= rf_vld_q[rs1_q] ? rf_mem[rs1_q] : rf_rst(rs1_q, SP_RST);
    b_q <= rf_vld_q[b_idx] ? rf_mem[b_idx] : rf_rst(b_idx, SP_RST);
    if (cmd_i.commit && wb_en_q && wb_rd_q != 5'd0) begin
      rf_mem[wb_rd_q] <= wb_data;
    end
  end

  // Data memory with clear sweep after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign ea = a_q + imm_q;
  assign mem_raddr = ea[AW+1:2];
  assign daddr_ext = {14'd0, daddr_q};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ea[AW+1:2];
    mem_wdata = b_q;
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = 32'd0;
    end else if (cmd_i.exec && func_q == F_DINIT) begin
      mem_we    = 1'b1;
      mem_waddr = daddr_ext[AW+1:2];
      mem_wdata = imm_q;
    end else if (cmd_i.exec && exe && func_q == F_SW) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= dmem[mem_raddr];
  end

  // Execute.
  assign eff = (32'(size_q) < CODE_LIM) ? 32'(size_q) : CODE_LIM;
  assign pc1 = pc_q + 32'd1;
  assign exe = (func_q != F_DINIT) && (status_q == ST_RUN) && (step_q < limit_q) &&
               (pc_q < eff);
  assign is_div = (func_q == F_DIV) || (func_q == F_REM);
  assign div_special = (b_q == 32'd0) || (a_q == 32'h8000_0000 && b_q == 32'hFFFF_FFFF);

  always_comb begin
    if (b_q == 32'd0) begin
      div_special_val = (func_q == F_REM) ? a_q : 32'hFFFF_FFFF;
    end else begin
      div_special_val = (func_q == F_REM) ? 32'd0 : 32'h8000_0000;
    end
  end

  always_comb begin
    stn_d      = status_q;
    npc_d      = pc_q;
    step_inc_d = 1'b0;
    wb_en_d    = 1'b0;
    wb_rd_d    = rd_q;
    wb_sel_d   = WB_ALU;
    alu_d      = 32'd0;
    taken      = 1'b0;
    if (func_q != F_DINIT && status_q == ST_RUN) begin
      if (step_q >= limit_q) begin
        stn_d = ST_LIMIT;
      end else begin
        step_inc_d = 1'b1;
        if (pc_q >= eff) begin
          stn_d = ST_PCOOR;
        end else begin
          npc_d   = pc1;
          wb_en_d = 1'b1;
          unique case (func_q)
            F_ADDI:  alu_d = a_q + imm_q;
            F_ADD:   alu_d = a_q + b_q;
            F_SUB:   alu_d = a_q - b_q;
            F_MUL:   alu_d = a_q * b_q;
            F_DIV, F_REM: begin
              alu_d    = div_special_val;
              wb_sel_d = div_special ? WB_ALU : WB_DIV;
            end
            F_SLT:   alu_d = {31'd0, $signed(a_q) < $signed(b_q)};
            F_SLTU:  alu_d = {31'd0, a_q < b_q};
            F_SLTIU: alu_d = {31'd0, a_q < imm_q};
            F_SLTI:  alu_d = {31'd0, $signed(a_q) < $signed(imm_q)};
            F_SLLI:  alu_d = a_q << imm_q[4:0];
            F_XORI:  alu_d = a_q ^ imm_q;
            F_SEQZ:  alu_d = {31'd0, a_q == 32'd0};
            F_SNEZ:  alu_d = {31'd0, a_q != 32'd0};
            F_LI:    alu_d = imm_q;
            F_MV:    alu_d = a_q;
            F_NEG:   alu_d = 32'd0 - a_q;
            F_LW:    wb_sel_d = WB_MEM;
            F_SW:    wb_en_d = 1'b0;
            F_LA:    alu_d = {14'd0, daddr_q};
            F_BEQZ: begin wb_en_d = 1'b0; taken = (a_q == 32'd0); end
            F_BEQ:  begin wb_en_d = 1'b0; taken = (a_q == b_q); end
            F_BNEZ: begin wb_en_d = 1'b0; taken = (a_q != 32'd0); end
            F_BNE:  begin wb_en_d = 1'b0; taken = (a_q != b_q); end
            F_BLT:  begin wb_en_d = 1'b0; taken = ($signed(a_q) < $signed(b_q)); end
            F_BGE:  begin wb_en_d = 1'b0; taken = !($signed(a_q) < $signed(b_q)); end
            F_J:    begin wb_en_d = 1'b0; taken = 1'b1; end
            F_JAL:  begin alu_d = pc1; taken = 1'b1; end
            F_CALL: begin alu_d = pc1; wb_rd_d = REG_RA; taken = 1'b1; end
            F_RET: begin
              wb_en_d = 1'b0;
              if (b_q >= eff) begin
                stn_d = ST_RET;
                npc_d = pc_q;
              end else begin
                npc_d = b_q;
              end
            end
            F_JALR: begin alu_d = pc1; npc_d = ea; end
            default: begin
              wb_en_d = 1'b0;
              stn_d   = ST_UNK;
              npc_d   = pc_q;
            end
          endcase
          if (taken) begin
            npc_d = {20'd0, tgt_q};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      npc_q      <= npc_d;
      stn_q      <= stn_d;
      step_inc_q <= step_inc_d;
      wb_en_q    <= wb_en_d;
      wb_rd_q    <= wb_rd_d;
      wb_sel_q   <= wb_sel_d;
      alu_q      <= alu_d;
    end
  end

  rvx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .rem_i   (func_q == F_REM),
    .a_i     (a_q),
    .b_i     (b_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    unique case (wb_sel_q)
      WB_MEM:  wb_data = mem_rdata_q;
      WB_DIV:  wb_data = div_res;
      default: wb_data = alu_q;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_o <= {5'd0, ((stn_q == ST_RET) ? a0_lo_q : 8'd0), stn_q, npc_q};
    end
  end

  assign sts_o.clear_done = (clr_cnt_q == AW'(MEM_WORDS - 1));
  assign sts_o.need_div   = exe && is_div && !div_special;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_o || out_ready_i;

`ifndef SYNTHESIS
  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != ST_RUN) |=> (status_q == $past(status_q)))
    else $error("terminal status changed");
  a_step_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == $past(step_q)) || (step_q == $past(step_q) + 32'd1))
    else $error("step count jumped");
  a_x0_never_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rf_vld_q[0])
    else $error("x0 written");
`endif
endmodule

`default_nettype wire

>>> tb/rv32_subset_instruction_executor_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rv32_subset_instruction_executor_tb
// Drives pre-decoded instructions and configuration writes into the executor,
// tracks the register file, memory, pc and run status in a local model, and
// compares every result word field by field under random stalls on both sides.
// -----------------------------------------------------------------------------
module rv32_subset_instruction_executor_tb;
  import rvx_pkg::*;

  localparam int unsigned MEM_WORDS  = 65536;
  localparam int unsigned CODE_DEPTH = 4096;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [5:0]  func;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [11:0] target;
    logic [17:0] daddr;
  } instr_t;

  typedef struct {
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic [7:0]  exit_code;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  rv32_subset_instruction_executor #(
    .MEM_WORDS (MEM_WORDS),
    .CODE_DEPTH(CODE_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Model state.
  logic [31:0] cpu_regs [32];
  logic [31:0] cpu_mem [int unsigned];
  logic [31:0] cpu_pc;
  logic [31:0] cpu_steps;
  logic [2:0]  cpu_status;
  logic [12:0] code_size_q;
  logic [11:0] entry_pc_q;
  logic [31:0] step_limit_q;

  outcome_t    expected_q [$];
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned cycle_count;
  bit          calm;
  logic [31:0] addr_pool [8];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] code_limit();
    return (code_size_q < CODE_DEPTH) ? 32'(code_size_q) : CODE_DEPTH;
  endfunction

  function automatic logic [31:0] mem_read(logic [31:0] byte_addr);
    int unsigned idx;
    idx = (byte_addr >> 2) % MEM_WORDS;
    return cpu_mem.exists(idx) ? cpu_mem[idx] : 32'd0;
  endfunction

  function automatic void mem_write(logic [31:0] byte_addr, logic [31:0] value);
    cpu_mem[(byte_addr >> 2) % MEM_WORDS] = value;
  endfunction

  function automatic void reg_write(logic [4:0] idx, logic [31:0] value);
    if (idx != 5'd0) cpu_regs[idx] = value;
  endfunction

  function automatic logic [31:0] divide(logic [31:0] a, logic [31:0] b, bit want_rem);
    if (b == 32'd0) return want_rem ? a : 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return want_rem ? 32'd0 : 32'h8000_0000;
    return want_rem ? 32'($signed(a) % $signed(b)) : 32'($signed(a) / $signed(b));
  endfunction

  function automatic outcome_t execute_instr(instr_t it);
    outcome_t    res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] npc;
    bit          taken;
    a = cpu_regs[it.rs1];
    b = cpu_regs[it.rs2];
    npc = cpu_pc + 32'd1;
    taken = 1'b0;
    if (it.func == F_DINIT) begin
      mem_write(32'(it.daddr), it.imm);
    end else if (cpu_status == ST_RUN) begin
      if (cpu_steps >= step_limit_q) begin
        cpu_status = ST_LIMIT;
      end else begin
        cpu_steps++;
        if (cpu_pc >= code_limit()) begin
          cpu_status = ST_PCOOR;
        end else begin
          case (it.func)
            F_ADDI:  reg_write(it.rd, a + it.imm);
            F_ADD:   reg_write(it.rd, a + b);
            F_SUB:   reg_write(it.rd, a - b);
            F_MUL:   reg_write(it.rd, a * b);
            F_DIV:   reg_write(it.rd, divide(a, b, 1'b0));
            F_REM:   reg_write(it.rd, divide(a, b, 1'b1));
            F_SLT:   reg_write(it.rd, {31'd0, $signed(a) < $signed(b)});
            F_SLTU:  reg_write(it.rd, {31'd0, a < b});
            F_SLTIU: reg_write(it.rd, {31'd0, a < it.imm});
            F_SLTI:  reg_write(it.rd, {31'd0, $signed(a) < $signed(it.imm)});
            F_SLLI:  reg_write(it.rd, a << it.imm[4:0]);
            F_XORI:  reg_write(it.rd, a ^ it.imm);
            F_SEQZ:  reg_write(it.rd, {31'd0, a == 32'd0});
            F_SNEZ:  reg_write(it.rd, {31'd0, a != 32'd0});
            F_LI:    reg_write(it.rd, it.imm);
            F_MV:    reg_write(it.rd, a);
            F_NEG:   reg_write(it.rd, 32'd0 - a);
            F_LW:    reg_write(it.rd, mem_read(a + it.imm));
            F_SW:    mem_write(a + it.imm, cpu_regs[it.rd]);
            F_LA:    reg_write(it.rd, 32'(it.daddr));
            F_BEQZ:  taken = (a == 32'd0);
            F_BEQ:   taken = (a == b);
            F_BNEZ:  taken = (a != 32'd0);
            F_BNE:   taken = (a != b);
            F_BLT:   taken = $signed(a) < $signed(b);
            F_BGE:   taken = !($signed(a) < $signed(b));
            F_J:     taken = 1'b1;
            F_JAL: begin
              reg_write(it.rd, cpu_pc + 32'd1);
              taken = 1'b1;
            end
            F_CALL: begin
              reg_write(REG_RA, cpu_pc + 32'd1);
              taken = 1'b1;
            end
            F_RET: begin
              if (cpu_regs[REG_RA] >= code_limit()) begin
                cpu_status = ST_RET;
                npc = cpu_pc;
              end else begin
                npc = cpu_regs[REG_RA];
              end
            end
            F_JALR: begin
              reg_write(it.rd, cpu_pc + 32'd1);
              npc = a + it.imm;
            end
            default: begin
              cpu_status = ST_UNK;
              npc = cpu_pc;
            end
          endcase
          if (taken) npc = 32'(it.target);
          cpu_pc = npc;
        end
      end
    end
    res.next_pc = cpu_pc;
    res.status = cpu_status;
    res.exit_code = (cpu_status == ST_RET) ? cpu_regs[REG_A0][7:0] : 8'd0;
    return res;
  endfunction

  function automatic instr_t mk(logic [5:0] func, logic [4:0] rd, logic [4:0] rs1,
                                logic [4:0] rs2, logic [31:0] imm, logic [11:0] target,
                                logic [17:0] daddr);
    instr_t it;
    it.func = func;
    it.rd = rd;
    it.rs1 = rs1;
    it.rs2 = rs2;
    it.imm = imm;
    it.target = target;
    it.daddr = daddr;
    return it;
  endfunction

  task automatic send_instr(instr_t it);
    while (!calm && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, it.daddr, it.target, it.imm, it.rs2, it.rs1, it.rd, it.func};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q = {expected_q, execute_instr(it)};
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CODE_SIZE: code_size_q = value[12:0];
      CFG_ENTRY_PC: begin
        entry_pc_q = value[11:0];
        if (cpu_steps == 32'd0 && cpu_status == ST_RUN) cpu_pc = 32'(entry_pc_q);
      end
      default: step_limit_q = value;
    endcase
    @(posedge clk_i);
  endtask

  // An instruction that keeps the program running, with random content.
  function automatic instr_t random_instr();
    instr_t it;
    it = mk(6'($urandom_range(0, 30)), 5'($urandom), 5'($urandom), 5'($urandom),
            $urandom, 12'($urandom), 18'($urandom));
    if ($urandom_range(0, 99) < 8) it.func = F_DINIT;
    if ($urandom_range(0, 3) == 0) it.rs2 = 5'($urandom_range(0, 3));
    case (it.func)
      F_LW, F_SW:
        if ($urandom_range(0, 1)) it.imm = addr_pool[$urandom_range(0, 7)] - cpu_regs[it.rs1];
      F_DINIT:
        if ($urandom_range(0, 1)) it.daddr = addr_pool[$urandom_range(0, 7)][17:0];
      F_JALR:
        it.imm = 32'($urandom_range(0, CODE_DEPTH - 1)) - cpu_regs[it.rs1];
      F_RET:
        if (cpu_regs[REG_RA] >= code_limit()) it.func = F_J;
      default: ;
    endcase
    return it;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    $display("mismatch on word %0d: %s expected 0x%08h got 0x%08h",
             words_checked, field, exp_v, got_v);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", 32'd0, m_axis_tdata[31:0]);
      end else begin
        if (m_axis_tdata[31:0] !== expected_q[0].next_pc)
          report_mismatch("next_pc", expected_q[0].next_pc, m_axis_tdata[31:0]);
        if (m_axis_tdata[34:32] !== expected_q[0].status)
          report_mismatch("status", 32'(expected_q[0].status), 32'(m_axis_tdata[34:32]));
        if (m_axis_tdata[42:35] !== expected_q[0].exit_code)
          report_mismatch("exit_code", 32'(expected_q[0].exit_code),
                          32'(m_axis_tdata[42:35]));
        void'(expected_q.pop_front());
      end
      words_checked++;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", expected_q.size());
      $display("rv32_subset_instruction_executor_tb: done, errors");
      $finish;
    end
  end

  task automatic test_preload();
    write_cfg(CFG_CODE_SIZE, 32'd0);
    write_cfg(CFG_ENTRY_PC, 32'd4095);
    write_cfg(CFG_STEP_LIMIT, 32'd0);
    send_instr(mk(F_DINIT, 5'd0, 5'd0, 5'd0, 32'h8000_0000, 12'd0, 18'h3FFFF));
    send_instr(mk(F_DINIT, 5'd31, 5'd31, 5'd31, 32'h7FFF_FFFF, 12'hFFF, 18'h00100));
    drain();
    write_cfg(CFG_CODE_SIZE, 32'd8191);
    write_cfg(CFG_STEP_LIMIT, 32'hFFFF_FFFF);
  endtask

  task automatic test_alu_corners();
    send_instr(mk(F_J, 5'd0, 5'd0, 5'd0, 32'd0, 12'd10, 18'd0));
    send_instr(mk(F_LI, 5'd5, 5'd0, 5'd0, 32'h8000_0000, 12'd0, 18'd0));
    send_instr(mk(F_LI, 5'd6, 5'd0, 5'd0, 32'hFFFF_FFFF, 12'd0, 18'd0));
    send_instr(mk(F_DIV, 5'd7, 5'd5, 5'd6, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_REM, 5'd8, 5'd5, 5'd6, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_DIV, 5'd9, 5'd5, 5'd0, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_REM, 5'd10, 5'd5, 5'd0, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_MUL, 5'd11, 5'd5, 5'd6, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_LI, 5'd0, 5'd0, 5'd0, 32'd123, 12'd0, 18'd0));
    send_instr(mk(F_ADDI, 5'd12, 5'd0, 5'd0, 32'h7FFF_FFFF, 12'd0, 18'd0));
    send_instr(mk(F_ADD, 5'd13, 5'd12, 5'd12, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_SUB, 5'd14, 5'd0, 5'd12, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_SLT, 5'd15, 5'd5, 5'd6, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_SLTU, 5'd15, 5'd5, 5'd6, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_SLTIU, 5'd16, 5'd6, 5'd0, 32'd5, 12'd0, 18'd0));
    send_instr(mk(F_SLTI, 5'd16, 5'd5, 5'd0, 32'hFFFF_FFFF, 12'd0, 18'd0));
    send_instr(mk(F_SLLI, 5'd17, 5'd6, 5'd0, 32'hFFFF_FFE3, 12'd0, 18'd0));
    send_instr(mk(F_XORI, 5'd18, 5'd5, 5'd0, 32'hFFFF_FFFF, 12'd0, 18'd0));
    send_instr(mk(F_SEQZ, 5'd19, 5'd0, 5'd0, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_SNEZ, 5'd19, 5'd5, 5'd0, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_MV, 5'd20, 5'd5, 5'd0, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_NEG, 5'd21, 5'd5, 5'd0, 32'd0, 12'd0, 18'd0));
  endtask

  task automatic test_memory_and_flow();
    send_instr(mk(F_LW, 5'd22, 5'd0, 5'd0, 32'h0000_0100, 12'd0, 18'd0));
    send_instr(mk(F_LW, 5'd22, 5'd6, 5'd0, 32'h0004_0000, 12'd0, 18'd0));
    send_instr(mk(F_SW, 5'd5, 5'd0, 5'd0, 32'h0000_0040, 12'd0, 18'd0));
    send_instr(mk(F_LW, 5'd23, 5'd0, 5'd0, 32'h0000_0043, 12'd0, 18'd0));
    send_instr(mk(F_LA, 5'd24, 5'd0, 5'd0, 32'd0, 12'd0, 18'h3FFFF));
    send_instr(mk(F_BEQZ, 5'd0, 5'd0, 5'd0, 32'd0, 12'd40, 18'd0));
    send_instr(mk(F_BEQ, 5'd0, 5'd5, 5'd6, 32'd0, 12'd7, 18'd0));
    send_instr(mk(F_BNEZ, 5'd0, 5'd0, 5'd0, 32'd0, 12'd9, 18'd0));
    send_instr(mk(F_BNE, 5'd0, 5'd5, 5'd6, 32'd0, 12'd50, 18'd0));
    send_instr(mk(F_BLT, 5'd0, 5'd5, 5'd6, 32'd0, 12'd60, 18'd0));
    send_instr(mk(F_BGE, 5'd0, 5'd5, 5'd6, 32'd0, 12'd70, 18'd0));
    send_instr(mk(F_CALL, 5'd0, 5'd0, 5'd0, 32'd0, 12'd100, 18'd0));
    send_instr(mk(F_RET, 5'd0, 5'd0, 5'd0, 32'd0, 12'd0, 18'd0));
    send_instr(mk(F_JAL, 5'd3, 5'd0, 5'd0, 32'd0, 12'd200, 18'd0));
    send_instr(mk(F_JALR, 5'd4, 5'd0, 5'd0, 32'd300, 12'd0, 18'd0));
  endtask

  task automatic test_random_program(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      calm = (n >= count / 3) && (n < count / 3 + 60);
      if (n == count / 2) begin
        drain();
        write_cfg(CFG_CODE_SIZE, 32'd4096);
        write_cfg(CFG_ENTRY_PC, 32'd0);
        write_cfg(CFG_STEP_LIMIT, 32'd100000);
      end
      send_instr(random_instr());
    end
    calm = 1'b0;
  endtask

  task automatic test_termination();
    instr_t it;
    case ($urandom_range(0, 3))
      0: send_instr(mk(6'($urandom_range(32, 63)), 5'($urandom), 5'($urandom), 5'($urandom),
                       $urandom, 12'($urandom), 18'($urandom)));
      1: begin
        send_instr(mk(F_LI, REG_RA, 5'd0, 5'd0, 32'($urandom_range(4096, 32'hFFFF_FFFF)),
                      12'd0, 18'd0));
        send_instr(mk(F_LI, REG_A0, 5'd0, 5'd0, $urandom, 12'd0, 18'd0));
        send_instr(mk(F_RET, 5'd0, 5'd0, 5'd0, 32'd0, 12'd0, 18'd0));
      end
      2: begin
        drain();
        write_cfg(CFG_CODE_SIZE, cpu_pc);
        send_instr(random_instr());
      end
      default: begin
        drain();
        write_cfg(CFG_STEP_LIMIT, cpu_steps);
        send_instr(random_instr());
      end
    endcase
    for (int n = 0; n < 16; n++) begin
      it = mk(6'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), $urandom,
              12'($urandom), 18'($urandom));
      send_instr(it);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CODE_SIZE;
    cfg_data_i = '0;
    calm = 1'b0;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    cycle_count = 0;
    foreach (cpu_regs[i]) cpu_regs[i] = 32'd0;
    cpu_regs[REG_SP] = 32'(MEM_WORDS * 4 - 16);
    cpu_regs[REG_RA] = 32'hFFFF_FFFF;
    code_size_q = '0;
    entry_pc_q = '0;
    step_limit_q = STEP_LIMIT_RST;
    cpu_pc = 32'd0;
    cpu_steps = 32'd0;
    cpu_status = ST_RUN;
    foreach (addr_pool[i]) addr_pool[i] = 32'h0002_0000 + 32'(i * 4);
    addr_pool[7] = 32'h0003_FFFC;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_preload();
    test_alu_corners();
    test_memory_and_flow();
    test_random_program(500);
    test_termination();
    drain();

    $display("Sent %0d instruction words and checked %0d results; final status %0d.",
             words_sent, words_checked, cpu_status);
    $display("Covered all operations, divider corners, memory preload and run end.");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("rv32_subset_instruction_executor_tb: done, clean");
    end else begin
      $display("rv32_subset_instruction_executor_tb: done, errors");
    end
    $finish;
  end

endmodule
